// ===== hdl/accumulator_add_and_logic_unit_core_defines.svh =====
// ----------------------------------------------------------------------------
// Accumulator ALU assertion macros
// Shared concurrent assertion forms for the ALU checker.
// ----------------------------------------------------------------------------
`ifndef ACCUMULATOR_ADD_AND_LOGIC_UNIT_CORE_DEFINES_SVH
`define ACCUMULATOR_ADD_AND_LOGIC_UNIT_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define AALU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define AALU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/aalu_pkg.sv =====
// ----------------------------------------------------------------------------
// Accumulator ALU package
// Operation and register codes, word types and the ADC adder function.
// ----------------------------------------------------------------------------
package aalu_pkg;

  typedef enum logic {
    OP_ADC = 1'b0,
    OP_AND = 1'b1
  } aalu_op_t;

  // configuration register indexes
  localparam logic CFG_BYTE_WIDTH = 1'b0;
  localparam logic CFG_DECIMAL    = 1'b1;

  localparam int unsigned DataW = 16;

  typedef struct packed {
    logic [DataW-1:0] sum;
    logic             c;
    logic             v;
  } aalu_add_t;

  // ADC: binary or packed BCD, 8 or 16 bits; narrow result sits in sum[7:0]
  function automatic aalu_add_t aalu_add(input logic [DataW-1:0] a,
                                         input logic [DataW-1:0] m,
                                         input logic cin,
                                         input logic narrow,
                                         input logic dec);
    aalu_add_t        res;
    logic [16:0]      s17;
    logic [8:0]       s9;
    logic [5:0]       ds;
    logic             c;
    logic [3:0]       top_b;
    logic [3:0]       cout_k;
    logic [DataW-1:0] dsum;
    s17 = {1'b0, a} + {1'b0, m} + {16'b0, cin};
    s9  = {1'b0, a[7:0]} + {1'b0, m[7:0]} + {8'b0, cin};
    c    = cin;
    dsum = '0;
    for (int k = 0; k < 4; k++) begin
      ds = {2'b0, a[4*k +: 4]} + {2'b0, m[4*k +: 4]} + {5'b0, c};
      // sign for V is taken before the digit is corrected
      top_b[k] = ds[3];
      if (ds >= 6'd10) begin
        ds = ds + 6'd6;
      end
      c = (ds >= 6'd16);
      cout_k[k] = c;
      dsum[4*k +: 4] = ds[3:0];
    end
    if (dec) begin
      res.sum = dsum;
      if (narrow) begin
        res.c = cout_k[1];
        res.v = (a[7] == m[7]) && (a[7] != top_b[1]);
      end else begin
        res.c = cout_k[3];
        res.v = (a[15] == m[15]) && (a[15] != top_b[3]);
      end
    end else begin
      res.sum = s17[15:0];
      if (narrow) begin
        res.c = s9[8];
        res.v = (a[7] == m[7]) && (a[7] != s9[7]);
      end else begin
        res.c = s17[16];
        res.v = (a[15] == m[15]) && (a[15] != s17[15]);
      end
    end
    return res;
  endfunction

endpackage

// ===== hdl/aalu_if.sv =====
// ----------------------------------------------------------------------------
// Accumulator ALU channels
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface aalu_req_if;
  import aalu_pkg::*;
  logic             valid;
  logic             ready;
  aalu_op_t         req_type;
  logic [DataW-1:0] operand;

  modport source (output valid, output req_type, output operand, input ready);
  modport sink   (input valid, input req_type, input operand, output ready);
endinterface

interface aalu_res_if;
  import aalu_pkg::*;
  logic             valid;
  logic             ready;
  logic [DataW-1:0] acc_value;
  logic             neg_flag;
  logic             ovf_flag;
  logic             zero_flag;
  logic             carry_flag;

  modport source (output valid, output acc_value, output neg_flag, output ovf_flag,
                  output zero_flag, output carry_flag, input ready);
  modport sink   (input valid, input acc_value, input neg_flag, input ovf_flag,
                  input zero_flag, input carry_flag, output ready);
endinterface

// ===== hdl/accumulator_add_and_logic_unit_core.sv =====
// ----------------------------------------------------------------------------
// Accumulator ALU core
// ADC and AND on a 16-bit accumulator with 8/16-bit width and decimal mode.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request word (req_type, operand); out_ch returns one
//   result word per request (accumulator and N, V, Z, C flags).
//   cfg_we/cfg_addr/cfg_wdata write the width and decimal mode registers;
//   write them only while no request is in flight.
// Pipeline: the input register loads at the request accept; the ALU result
//   goes into the result register once that register can move, and the
//   result word can be taken from there.
// Throughput: one word per cycle while out_ch.ready holds. The accumulator feedback
//   through the adder with decimal correction is the loop that sets this.
// Reset: accumulator, carry and overflow clear, 8-bit mode, binary mode, both
//   pipeline registers empty.
// Stall: a held result keeps its word; one more request waits in the input
//   register, after which in_ch.ready drops until out_ch.ready returns.
// ----------------------------------------------------------------------------
module accumulator_add_and_logic_unit_core (
  input  logic                    clk,
  input  logic                    rst_n,
  aalu_req_if.sink                in_ch,
  aalu_res_if.source              out_ch,
  input  logic                    cfg_we,
  input  logic                    cfg_addr,
  input  logic                    cfg_wdata
);
  import aalu_pkg::*;

  logic             byte_mode_r;
  logic             dec_mode_r;
  logic [DataW-1:0] acc_r;
  logic             carry_r;
  logic             ovf_r;

  logic             s1_v_r;
  aalu_op_t         s1_op_r;
  logic [DataW-1:0] s1_opnd_r;

  logic             out_v_r;
  logic [DataW-1:0] out_acc_r;
  logic             out_n_r;
  logic             out_v_flag_r;
  logic             out_z_r;
  logic             out_c_r;

  logic             fire;
  aalu_add_t        add_res;
  logic [DataW-1:0] res;
  logic [DataW-1:0] acc_nxt;
  logic             carry_nxt;
  logic             ovf_nxt;
  logic             neg_nxt;
  logic             zero_nxt;

  assign fire        = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || fire;

  always_comb begin
    add_res   = aalu_add(acc_r, s1_opnd_r, carry_r, byte_mode_r, dec_mode_r);
    carry_nxt = carry_r;
    ovf_nxt   = ovf_r;
    if (s1_op_r == OP_ADC) begin
      res       = add_res.sum;
      carry_nxt = add_res.c;
      ovf_nxt   = add_res.v;
    end else begin
      res = acc_r & s1_opnd_r;
    end
    if (byte_mode_r) begin
      acc_nxt  = {acc_r[15:8], res[7:0]};
      neg_nxt  = res[7];
      zero_nxt = (res[7:0] == 8'h00);
    end else begin
      acc_nxt  = res;
      neg_nxt  = res[15];
      zero_nxt = (res == 16'h0000);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_mode_r <= 1'b1;
      dec_mode_r  <= 1'b0;
      acc_r       <= '0;
      carry_r     <= 1'b0;
      ovf_r       <= 1'b0;
      s1_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_BYTE_WIDTH: byte_mode_r <= cfg_wdata;
          CFG_DECIMAL:    dec_mode_r  <= cfg_wdata;
          default:        ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        s1_v_r <= 1'b1;
      end else if (fire) begin
        s1_v_r <= 1'b0;
      end
      if (fire) begin
        out_v_r <= 1'b1;
        acc_r   <= acc_nxt;
        carry_r <= carry_nxt;
        ovf_r   <= ovf_nxt;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_op_r   <= in_ch.req_type;
      s1_opnd_r <= in_ch.operand;
    end
    if (fire) begin
      out_acc_r    <= acc_nxt;
      out_n_r      <= neg_nxt;
      out_v_flag_r <= ovf_nxt;
      out_z_r      <= zero_nxt;
      out_c_r      <= carry_nxt;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.acc_value  = out_acc_r;
  assign out_ch.neg_flag   = out_n_r;
  assign out_ch.ovf_flag   = out_v_flag_r;
  assign out_ch.zero_flag  = out_z_r;
  assign out_ch.carry_flag = out_c_r;

endmodule

// ===== hdl/aalu_checker.sv =====
// ----------------------------------------------------------------------------
// Accumulator ALU checker
// Port-level checks on the ALU core, attached by bind.
// ----------------------------------------------------------------------------
`include "accumulator_add_and_logic_unit_core_defines.svh"

module aalu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_acc_value,
  input logic        out_neg_flag,
  input logic        out_zero_flag
);

  // a held result word must not change
  `AALU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_acc_value))

  // free output side means the core takes a request
  `AALU_ASSERT_NOW(a_in_ready, !out_valid || out_ready, in_ready)

  // an accepted word reaches the output once the result register can move
  `AALU_ASSERT_NEXT(a_latency, $past(in_valid && in_ready) && (out_ready || !out_valid),
                    out_valid)

  // Z implies a zero low byte and N matches bit 15 or bit 7, in either width
  `AALU_ASSERT_NOW(a_zero_low, out_valid && out_zero_flag, out_acc_value[7:0] == 8'h00)
  `AALU_ASSERT_NOW(a_neg_bit, out_valid,
                   out_neg_flag == out_acc_value[15] || out_neg_flag == out_acc_value[7])

endmodule

bind accumulator_add_and_logic_unit_core aalu_checker u_aalu_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_acc_value (out_ch.acc_value),
  .out_neg_flag  (out_ch.neg_flag),
  .out_zero_flag (out_ch.zero_flag)
);
